// ----- hw/rtl/prbd_pkg.sv -----
// Shared types and constants for the pixel row bit decoder.
`timescale 1ns / 1ps
package prbd_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned TOTAL_W     = 10;
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned BIT_CNT_W   = $clog2(BYTE_BITS);
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [TOTAL_W-1:0] BYTES_MAX    = TOTAL_W'(512);
  localparam logic [PIX_W-1:0]   ZERO_THR_RST = PIX_W'(130);
  localparam logic [PIX_W-1:0]   ONE_THR_RST  = PIX_W'(220);

  // configuration register indexes
  typedef enum logic {
    CFG_ZERO_THR = 1'b0,
    CFG_ONE_THR  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] zero_thr;
    logic [PIX_W-1:0] one_thr;
  } thr_t;

  typedef struct packed {
    logic               is_status;
    logic [PIX_W-1:0]   byte_value;
    logic               row_ok;
    logic [TOTAL_W-1:0] byte_total;
  } result_t;

  // up to two results per pixel: a data byte, then a row status
  typedef struct packed {
    logic    byte_vld;
    logic    stat_vld;
    result_t byte_item;
    result_t stat_item;
  } push_t;

endpackage

// ----- hw/rtl/pixel_row_bit_decoder_unit.sv -----
// Top level of the pixel row bit decoder.
`timescale 1ns / 1ps
// Each result is registered in the result queue and offered from its head, in order.
// Throughput: one pixel per cycle; a pixel that ends a byte and its row queues two
// results, and in_stall rises only while the 4-entry result queue lacks room for two.
// Reset (rst_n, synchronous, active low) restores thresholds 130/220, clears row state
// and empties the queue; no clearing pass follows.
module pixel_row_bit_decoder_unit #(
  parameter int unsigned CODE_PITCH     = 8,
  parameter int unsigned START_PIXELS   = 4,
  parameter int unsigned MAX_ROW_PIXELS = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // pixel input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [prbd_pkg::PIX_W-1:0]   in_pixel_value,
  input  logic                         in_row_end,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_is_status,
  output logic [prbd_pkg::PIX_W-1:0]   out_byte_value,
  output logic                         out_row_ok,
  output logic [prbd_pkg::TOTAL_W-1:0] out_byte_total,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [prbd_pkg::PIX_W-1:0]   cfg_data
);
  import prbd_pkg::*;

  thr_t    thr;
  push_t   push;
  result_t head;
  logic    accept;
  logic    full2;

  // register writes are taken every cycle
  assign cfg_ready = 1'b1;

  prbd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .thr      (thr)
  );

  // an accepted pixel steps the row one column, up to MAX_ROW_PIXELS, or ends the row
  assign in_stall = full2;
  assign accept   = in_valid & ~in_stall;

  prbd_decode #(
    .CODE_PITCH     (CODE_PITCH),
    .START_PIXELS   (START_PIXELS),
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
  ) u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .pixel_value (in_pixel_value),
    .row_end     (in_row_end),
    .thr         (thr),
    .push        (push)
  );

  // byte first, then status, in queue order
  prbd_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full2     (full2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (head)
  );

  assign out_is_status  = head.is_status;
  assign out_byte_value = head.byte_value;
  assign out_row_ok     = head.row_ok;
  assign out_byte_total = head.byte_total;

endmodule

// ----- hw/rtl/prbd_cfg_regs.sv -----
// Threshold configuration registers.
`timescale 1ns / 1ps
module prbd_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic                      wr_index,
  input  logic [prbd_pkg::PIX_W-1:0] wr_data,
  output prbd_pkg::thr_t            thr
);
  import prbd_pkg::*;

  thr_t thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.zero_thr <= ZERO_THR_RST;
      thr_r.one_thr  <= ONE_THR_RST;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_ZERO_THR: thr_r.zero_thr <= wr_data;
        CFG_ONE_THR:  thr_r.one_thr  <= wr_data;
        default:      thr_r          <= thr_r;
      endcase
    end
  end

  assign thr = thr_r;

endmodule

// ----- hw/rtl/prbd_decode.sv -----
// Per-row decode state machine: start check, white skip, pair sampling.
`timescale 1ns / 1ps
module prbd_decode #(
  parameter int unsigned CODE_PITCH     = 8,
  parameter int unsigned START_PIXELS   = 4,
  parameter int unsigned MAX_ROW_PIXELS = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [prbd_pkg::PIX_W-1:0] pixel_value,
  input  logic                       row_end,
  input  prbd_pkg::thr_t             thr,
  output prbd_pkg::push_t            push
);
  import prbd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ROW_PIXELS + 1);
  localparam int unsigned SW = $clog2(CODE_PITCH);
  localparam logic [CW-1:0] COL_MAX   = CW'(MAX_ROW_PIXELS);
  localparam logic [CW:0]   START_LEN = (CW + 1)'(START_PIXELS);
  localparam logic [SW-1:0] CD_HALF   = SW'(CODE_PITCH / 2);
  localparam logic [SW-1:0] CD_RELOAD = SW'(CODE_PITCH - 1);
  localparam logic [SW-1:0] CD_ONE    = SW'(1);

  typedef enum logic [1:0] {
    PH_START,
    PH_SKIP,
    PH_SAMPLE,
    PH_DONE
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic [SW-1:0]        cd_r, cd_nxt;
  logic [PIX_W-1:0]     held_r, held_nxt;
  logic [BYTE_BITS-1:0] shift_r, shift_nxt;
  logic [BIT_CNT_W-1:0] bcnt_r, bcnt_nxt;
  logic [TOTAL_W-1:0]   made_r, made_nxt;
  logic [PIX_W:0]       pair_sum;
  logic                 bit_zero, bit_one;
  push_t                push_nxt;

  assign pair_sum = {1'b0, held_r} + {1'b0, pixel_value};
  assign bit_zero = pair_sum < {thr.zero_thr, 1'b0};
  assign bit_one  = pair_sum < {thr.one_thr, 1'b0};

  always_comb begin
    phase_nxt = phase_r;
    col_nxt   = col_r;
    cd_nxt    = cd_r;
    held_nxt  = held_r;
    shift_nxt = shift_r;
    bcnt_nxt  = bcnt_r;
    made_nxt  = made_r;
    push_nxt  = '0;

    if (col_r < COL_MAX) begin
      unique case (phase_r)
        PH_START: begin
          if (pixel_value <= thr.one_thr) begin
            phase_nxt = PH_DONE;
          end else if (({1'b0, col_r} + (CW + 1)'(1)) >= START_LEN) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (pixel_value < thr.one_thr) begin
            phase_nxt = PH_SAMPLE;
            cd_nxt    = CD_HALF;
          end
        end
        PH_SAMPLE: begin
          if (cd_r == '0) begin
            if (bit_zero || bit_one) begin
              // bit is 1 only when the sum clears the zero level
              if (!bit_zero) begin
                shift_nxt = shift_r | (BYTE_BITS'(1) << bcnt_r);
              end
              if (bcnt_r == BIT_CNT_W'(BYTE_BITS - 1)) begin
                push_nxt.byte_vld             = 1'b1;
                push_nxt.byte_item.byte_value = shift_nxt;
                if (made_r < BYTES_MAX) begin
                  made_nxt = made_r + TOTAL_W'(1);
                end
                shift_nxt = '0;
                bcnt_nxt  = '0;
              end else begin
                bcnt_nxt = bcnt_r + BIT_CNT_W'(1);
              end
              cd_nxt = CD_RELOAD;
            end else begin
              phase_nxt = PH_DONE;
            end
          end else begin
            if (cd_r == CD_ONE) begin
              held_nxt = pixel_value;
            end
            cd_nxt = cd_r - CD_ONE;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
      col_nxt = col_r + CW'(1);
    end

    if (row_end) begin
      push_nxt.stat_vld             = 1'b1;
      push_nxt.stat_item.is_status  = 1'b1;
      push_nxt.stat_item.row_ok     = made_nxt != '0;
      push_nxt.stat_item.byte_total = made_nxt;
      phase_nxt = PH_START;
      col_nxt   = '0;
      cd_nxt    = '0;
      held_nxt  = '0;
      shift_nxt = '0;
      bcnt_nxt  = '0;
      made_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      col_r   <= '0;
      cd_r    <= '0;
      held_r  <= '0;
      shift_r <= '0;
      bcnt_r  <= '0;
      made_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      cd_r    <= cd_nxt;
      held_r  <= held_nxt;
      shift_r <= shift_nxt;
      bcnt_r  <= bcnt_nxt;
      made_r  <= made_nxt;
    end
  end

  always_comb begin
    push          = push_nxt;
    push.byte_vld = push_nxt.byte_vld & accept;
    push.stat_vld = push_nxt.stat_vld & accept;
  end

endmodule

// ----- hw/rtl/prbd_out_queue.sv -----
// Result queue: takes up to two results per cycle, hands out one.
`timescale 1ns / 1ps
module prbd_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  prbd_pkg::push_t   push,
  output logic              full2,
  output logic              out_valid,
  input  logic              out_stall,
  output prbd_pkg::result_t out_item
);
  import prbd_pkg::*;

  result_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r, wr_second;
  logic [QCNT_W-1:0] cnt_r;
  logic              pop, push_any;
  logic [QCNT_W-1:0] n_push;

  assign pop       = out_valid & ~out_stall;
  assign push_any  = push.byte_vld | push.stat_vld;
  assign n_push    = QCNT_W'(push.byte_vld) + QCNT_W'(push.stat_vld);
  assign wr_second = wr_r + QPTR_W'(push.byte_vld);

  always_ff @(posedge clk) begin
    if (push.byte_vld) begin
      mem_r[wr_r] <= push.byte_item;
    end
    if (push.stat_vld) begin
      mem_r[wr_second] <= push.stat_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + QPTR_W'(n_push);
      rd_r  <= rd_r + QPTR_W'(pop);
      cnt_r <= cnt_r + n_push - QCNT_W'(pop);
    end
  end

  // room for two more is needed before taking a pixel
  assign full2     = cnt_r > QCNT_W'(QDEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_item  = mem_r[rd_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue count overflow");

  a_two_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (push.byte_vld && push.stat_vld) |-> cnt_r <= QCNT_W'(QDEPTH - 2))
    else $error("double push without room");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push_any) |=> cnt_r == $past(cnt_r) - QCNT_W'(1))
    else $error("count did not drop on pop");

endmodule

// ----- test/pixel_row_bit_decoder_unit_tb.sv -----
// Self-checking testbench for the pixel row bit decoder: random rows, stalls and threshold sweeps.
`timescale 1ns / 1ps
module pixel_row_bit_decoder_unit_tb;
  import prbd_pkg::*;

  localparam int CODE_PITCH     = 8;
  localparam int START_PIXELS   = 4;
  localparam int MAX_ROW_PIXELS = 4096;

  localparam int PHASES        = 8;
  localparam int PHASE_PIXELS  = 150;  // random pixels per threshold setting
  localparam int HOLD_PHASE    = 3;    // phase in which the receiver blocks for a long stretch
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;    // margin after the last predicted result is seen

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             row_end;
  } pixel_t;

  typedef enum logic [1:0] {
    ROW_START,
    ROW_SKIP,
    ROW_SAMPLE,
    ROW_DONE
  } row_phase_e;

  // ---------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [PIX_W-1:0]   in_pixel_value = '0;
  logic               in_row_end     = 1'b0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic               out_is_status;
  logic [PIX_W-1:0]   out_byte_value;
  logic               out_row_ok;
  logic [TOTAL_W-1:0] out_byte_total;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  cfg_idx_t           cfg_index      = CFG_ZERO_THR;
  logic [PIX_W-1:0]   cfg_data       = '0;

  pixel_row_bit_decoder_unit #(
    .CODE_PITCH    (CODE_PITCH),
    .START_PIXELS  (START_PIXELS),
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_value(in_pixel_value),
    .in_row_end    (in_row_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_is_status (out_is_status),
    .out_byte_value(out_byte_value),
    .out_row_ok    (out_row_ok),
    .out_byte_total(out_byte_total),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  pixel_t  pending_pixels[$];    // pixels waiting for the driver
  pixel_t  row_buf[$];           // row under construction
  result_t expected_results[$];  // predicted bytes and row status, oldest first
  int      errors        = 0;
  int      items_sent    = 0;

  // traffic knobs, written by the stimulus process on the falling edge
  int      stall_pct     = 0;
  int      gap_max       = 0;
  int      hold_req_cnt  = 0;

  // ---------------------------------------------------------------------------
  // Row decoder prediction: own copy of thresholds and per-row state
  // ---------------------------------------------------------------------------
  thr_t              model_thr = '{zero_thr: ZERO_THR_RST, one_thr: ONE_THR_RST};
  row_phase_e        row_phase;
  logic [12:0]       col_cnt;
  logic [2:0]        pair_cd;     // pixels left until the second pixel of the next pair
  logic [PIX_W-1:0]  pair_first;
  logic [7:0]        bits_acc;
  logic [2:0]        bits_cnt;
  logic [TOTAL_W-1:0] byte_cnt;

  function automatic void clear_row();
    row_phase  = ROW_START;
    col_cnt    = '0;
    pair_cd    = '0;
    pair_first = '0;
    bits_acc   = '0;
    bits_cnt   = '0;
    byte_cnt   = '0;
  endfunction

  // Advances the row state by one pixel and queues the results it causes:
  // a finished byte first, then the row status on the last pixel.
  function automatic void decode_pixel(input logic [PIX_W-1:0] px, input logic row_last);
    int      pair_sum;
    int      bit_val;
    result_t r;
    bit_val = 0;
    if (int'(col_cnt) < MAX_ROW_PIXELS) begin
      case (row_phase)
        ROW_START: begin
          // start marker: every pixel strictly above the white level
          if (px <= model_thr.one_thr) row_phase = ROW_DONE;
          else if (int'(col_cnt) + 1 >= START_PIXELS) row_phase = ROW_SKIP;
        end
        ROW_SKIP: begin
          if (px < model_thr.one_thr) begin
            row_phase = ROW_SAMPLE;
            pair_cd   = 3'(CODE_PITCH / 2);
          end
        end
        ROW_SAMPLE: begin
          if (pair_cd == 3'd0) begin
            pair_sum = int'(pair_first) + int'(px);
            if (pair_sum < 2 * int'(model_thr.zero_thr)) begin
              bit_val = 0;
            end else if (pair_sum < 2 * int'(model_thr.one_thr)) begin
              bit_val = 1;
            end else begin
              bit_val   = 2;  // too bright: no more bits in this row
              row_phase = ROW_DONE;
            end
            if (bit_val < 2) begin
              bits_acc = bits_acc | (8'(bit_val) << bits_cnt);
              if (bits_cnt == 3'd7) begin
                r            = '0;
                r.byte_value = bits_acc;
                expected_results = {expected_results, r};
                if (byte_cnt < BYTES_MAX) byte_cnt++;
                bits_acc = '0;
                bits_cnt = '0;
              end else begin
                bits_cnt++;
              end
              pair_cd = 3'(CODE_PITCH - 1);
            end
          end else begin
            if (pair_cd == 3'd1) pair_first = px;
            pair_cd--;
          end
        end
        default: ;
      endcase
      col_cnt++;
    end
    if (row_last) begin
      r            = '0;
      r.is_status  = 1'b1;
      r.row_ok     = (byte_cnt != '0);
      r.byte_total = byte_cnt;
      expected_results = {expected_results, r};
      clear_row();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of pixels with random gaps; payload holds while stalled
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : pixel_driver
    pixel_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_pixel(in_pixel_value, in_row_end);
      // free to present a new transaction only once the current one is gone
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          nxt = pending_pixels.pop_front();
          in_valid       <= 1'b1;
          in_pixel_value <= nxt.value;
          in_row_end     <= nxt.row_end;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(24, 1);
            if (gap_max == 0 || $urandom_range(2, 0) == 0) gap_left = 0;
            else gap_left = $urandom_range(gap_max, 1);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern: runs of stall / no stall, plus a long hold on request
  // ---------------------------------------------------------------------------
  int  hold_seen = 0;
  int  hold_left = 0;
  int  run_left  = 0;
  bit  run_stall = 1'b0;

  always @(posedge clk) begin : result_stall_gen
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_left  = $urandom_range(12, 1);
        run_stall = ($urandom_range(99, 0) < stall_pct);
      end
      run_left--;
      out_stall <= run_stall;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted result transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [TOTAL_W-1:0] exp_v,
                             input logic [TOTAL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: extra result, expected none, actual %0d/%0d/%0d/%0d", $time,
                 out_is_status, out_byte_value, out_row_ok, out_byte_total);
      end else begin
        exp_r = expected_results.pop_front();
        check_field("is_status", TOTAL_W'(exp_r.is_status), TOTAL_W'(out_is_status));
        check_field("byte_value", TOTAL_W'(exp_r.byte_value), TOTAL_W'(out_byte_value));
        check_field("row_ok", TOTAL_W'(exp_r.row_ok), TOTAL_W'(out_row_ok));
        check_field("byte_total", exp_r.byte_total, out_byte_total);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int rand_pix();
    return $urandom_range(255, 0);
  endfunction

  // strictly above the white level (start marker); 255 when the white level is 255
  function automatic int start_pix();
    if (model_thr.one_thr == 8'hFF) return 255;
    return $urandom_range(255, int'(model_thr.one_thr) + 1);
  endfunction

  // at or above the white level (skipped)
  function automatic int white_pix();
    return $urandom_range(255, int'(model_thr.one_thr));
  endfunction

  function automatic int dark_pix();
    if (model_thr.one_thr == 8'h00) return 0;
    return $urandom_range(int'(model_thr.one_thr) - 1, 0);
  endfunction

  task automatic add_pix(input int v);
    pixel_t p;
    p.value   = 8'(v);
    p.row_end = 1'b0;
    row_buf   = {row_buf, p};
  endtask

  // marks the last pixel as row end and hands the row to the driver
  task automatic close_row();
    pixel_t p;
    p              = row_buf.pop_back();
    p.row_end      = 1'b1;
    row_buf        = {row_buf, p};
    pending_pixels = {pending_pixels, row_buf};
    items_sent += row_buf.size();
    row_buf.delete();
  endtask

  // pair pixels aimed at one bit value, now and then right on a threshold edge
  task automatic add_pair(input int want);
    int z, o, s, a, b;
    z = int'(model_thr.zero_thr);
    o = int'(model_thr.one_thr);
    case ($urandom_range(7, 0))
      0: begin
        case ($urandom_range(3, 0))
          0: s = 2 * z - 1;
          1: s = 2 * z;
          2: s = 2 * o - 1;
          default: s = 2 * o;
        endcase
        if (s < 0) s = 0;
        a = s / 2;
        b = s - a;
      end
      default: begin
        if (want == 0 && z > 0) begin
          a = $urandom_range(z - 1, 0);
          b = $urandom_range(z - 1, 0);
        end else if (want == 1 && z < o) begin
          a = $urandom_range(o - 1, z);
          b = $urandom_range(o - 1, z);
        end else begin
          a = rand_pix();
          b = rand_pix();
        end
      end
    endcase
    add_pix(a);
    add_pix(b);
  endtask

  // well-formed row: start marker, white run, dark sync, nbits pairs,
  // optionally a too-bright pair, then either the row ends or a random tail
  task automatic add_code_row(input int nbits, input int white_run, input bit end_on_pair,
                              input bit stop_pair);
    repeat (START_PIXELS) add_pix(start_pix());
    repeat (white_run) add_pix(white_pix());
    add_pix(dark_pix());
    for (int i = 0; i < nbits + int'(stop_pair); i++) begin
      repeat ((i == 0) ? CODE_PITCH / 2 - 1 : CODE_PITCH - 2) add_pix(rand_pix());
      if (i == nbits) begin
        add_pix(255);
        add_pix(255);
      end else begin
        add_pair($urandom_range(1, 0));
      end
    end
    if (!end_on_pair) repeat ($urandom_range(8, 1)) add_pix(rand_pix());
    close_row();
  endtask

  task automatic add_random_row();
    int mode, k, nbits;
    mode = $urandom_range(9, 0);
    if (mode == 0) begin
      // noise, sometimes behind a valid start marker
      if ($urandom_range(1, 0) == 1) repeat (START_PIXELS) add_pix(start_pix());
      repeat ($urandom_range(30, 1)) add_pix(rand_pix());
      close_row();
    end else if (mode == 1) begin
      // start marker broken by one pixel at or below the white level
      k = $urandom_range(START_PIXELS - 1, 0);
      for (int i = 0; i < START_PIXELS; i++) begin
        if (i == k) add_pix($urandom_range(int'(model_thr.one_thr), 0));
        else add_pix(start_pix());
      end
      repeat ($urandom_range(12, 0)) add_pix(rand_pix());
      close_row();
    end else begin
      nbits = 8 * $urandom_range(2, 0);
      if ($urandom_range(2, 0) == 0) nbits += $urandom_range(7, 1);  // leftover bits
      add_code_row(nbits, $urandom_range(5, 0), $urandom_range(3, 0) == 0,
                   $urandom_range(1, 0) == 1);
    end
  endtask

  // register write transaction; only issued while the block is idle
  task automatic write_reg(input cfg_idx_t idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 8'(val);
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ZERO_THR) model_thr.zero_thr = 8'(val);
    else model_thr.one_thr = 8'(val);
    cfg_valid <= 1'b0;
  endtask

  // sender pauses until every predicted result has been seen
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  int zero_tab [PHASES] = '{130, 0, 255, 60, 200, 255, 0, 90};
  int one_tab  [PHASES] = '{220, 255, 0, 200, 100, 255, 0, 180};
  int stall_tab[PHASES] = '{0, 30, 10, 60, 85, 20, 0, 40};
  int gap_tab  [PHASES] = '{0, 4, 2, 1, 8, 3, 0, 6};

  initial begin : stimulus
    int start_items, zt, ot;
    clear_row();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows at the reset thresholds
    add_pix(255);                       // short row: ends on its first pixel
    close_row();
    add_pix(220);                       // start pixel exactly at the white level fails
    add_pix(255);
    add_pix(0);
    close_row();
    add_pix(221);                       // all-white row, never a dark column
    add_pix(255);
    add_pix(255);
    add_pix(221);
    add_pix(220);
    add_pix(255);
    close_row();
    repeat (START_PIXELS) add_pix(255); // one bit sampled, dropped at row end
    add_pix(0);
    add_pix(128);
    add_pix(64);
    add_pix(32);
    add_pix(0);
    add_pix(0);
    add_pix(255);
    close_row();
    wait_idle();

    // random rows across threshold settings, extremes included
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) wait_idle();
      zt = zero_tab[p];
      ot = one_tab[p];
      if (p == PHASES - 1) begin
        zt = $urandom_range(255, 0);
        ot = $urandom_range(255, 0);
      end
      write_reg(CFG_ONE_THR, ot);
      write_reg(CFG_ZERO_THR, zt);
      @(negedge clk);
      stall_pct   = stall_tab[p];
      gap_max     = gap_tab[p];
      start_items = items_sent;
      if (p == HOLD_PHASE) begin
        // receiver blocks while a run of short rows fills the result queue
        hold_req_cnt++;
        repeat (12) begin
          repeat ($urandom_range(3, 1)) add_pix(rand_pix());
          close_row();
        end
      end
      while (items_sent - start_items < PHASE_PIXELS) add_random_row();
    end

    wait_idle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
